@@ src/skst_pkg.sv @@
// shared types and codes for the sorted key set table
package skst_pkg;

    localparam int KEY_W    = 31;
    localparam int STATUS_W = 4;
    localparam int ACTION_W = 2;

    typedef logic [KEY_W-1:0]    key_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [ACTION_W-1:0] action_t;

    localparam action_t ACT_LOOKUP = 2'd0;
    localparam action_t ACT_INSERT = 2'd1;
    localparam action_t ACT_DELETE = 2'd2;
    localparam action_t ACT_DUMP   = 2'd3;

    localparam status_t ST_FOUND    = 4'd0;
    localparam status_t ST_NOTFOUND = 4'd1;
    localparam status_t ST_INSERTED = 4'd2;
    localparam status_t ST_PRESENT  = 4'd3;
    localparam status_t ST_REMOVED  = 4'd4;
    localparam status_t ST_ABSENT   = 4'd5;
    localparam status_t ST_FULL     = 4'd6;
    localparam status_t ST_LISTED   = 4'd7;
    localparam status_t ST_EMPTY    = 4'd8;

endpackage

@@ src/sorted_key_set_table.sv @@
// sorted key set table: lookup, insert, delete and dump over a ram of sorted keys
// lookup/insert/delete: scan the stored keys from the bottom up to the key's position,
//   move the keys above it one slot for an insert or delete, then decide and emit
// dump: one ram read and one output word per stored key, an empty table gives one word
// one request at a time, idle between requests; the single ram read port sets the pace
// reset: entry count cleared, key ram left as is (entries above the count are never read)
module sorted_key_set_table
    import skst_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  action_t action,
    input  key_t    key,
    output logic    out_valid,
    input  logic    out_ready,
    output status_t status,
    output key_t    key_out,
    output logic    last
);

    localparam int ADDR_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

    // sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_SRD      = 4'd1;  // scan: issue read
    localparam logic [3:0] S_SCMP     = 4'd2;  // scan: compare read word
    localparam logic [3:0] S_DECIDE   = 4'd3;
    localparam logic [3:0] S_IRD      = 4'd4;  // insert shift: read lower neighbor
    localparam logic [3:0] S_IWR      = 4'd5;  // insert shift: write one slot up
    localparam logic [3:0] S_DRD      = 4'd6;  // delete shift: read upper neighbor
    localparam logic [3:0] S_DWR      = 4'd7;  // delete shift: write one slot down
    localparam logic [3:0] S_DUMP_RD  = 4'd8;
    localparam logic [3:0] S_DUMP_OUT = 4'd9;
    localparam logic [3:0] S_EMIT     = 4'd10;

    logic [3:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] pos_reg, pos_next;
    logic             found_reg, found_next;
    action_t          action_reg, action_next;
    key_t             key_reg, key_next;
    status_t          res_reg, res_next;

    // output word register
    logic    out_valid_reg, out_valid_next;
    status_t status_reg, status_next;
    key_t    key_out_reg, key_out_next;
    logic    last_reg, last_next;

    // ram port signals
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    key_t              wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    key_t              rd_data;

    logic [CNT_W-1:0] idx_inc;
    logic [CNT_W-1:0] idx_dec;
    logic             out_free;
    logic             accept;

    assign idx_inc  = CNT_W'(idx_reg + 1'b1);
    assign idx_dec  = CNT_W'(idx_reg - 1'b1);
    // output register can take a word this cycle
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;

    skst_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        pos_next       = pos_reg;
        found_next     = found_reg;
        action_next    = action_reg;
        key_next       = key_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        key_out_next   = key_out_reg;
        last_next      = last_reg;
        wr_en          = 1'b0;
        wr_addr        = idx_reg[ADDR_W-1:0];
        wr_data        = rd_data;
        rd_en          = 1'b0;
        rd_addr        = idx_reg[ADDR_W-1:0];

        // the consumer drains the output register
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    action_next = action;
                    key_next    = key;
                    idx_next    = '0;
                    if (action == ACT_DUMP)
                    begin
                        if (count_reg == '0)
                        begin
                            // empty table: one word with a zero key
                            res_next   = ST_EMPTY;
                            key_next   = '0;
                            state_next = S_EMIT;
                        end
                        else
                        begin
                            state_next = S_DUMP_RD;
                        end
                    end
                    else
                    begin
                        state_next = S_SRD;
                    end
                end
            end

            S_SRD:
            begin
                if (idx_reg == count_reg)
                begin
                    // ran off the end: key goes after every stored key
                    pos_next   = idx_reg;
                    found_next = 1'b0;
                    state_next = S_DECIDE;
                end
                else
                begin
                    rd_en      = 1'b1;
                    state_next = S_SCMP;
                end
            end

            S_SCMP:
            begin
                if (rd_data < key_reg)
                begin
                    idx_next   = idx_inc;
                    state_next = S_SRD;
                end
                else
                begin
                    pos_next   = idx_reg;
                    found_next = (rd_data == key_reg);
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                state_next = S_EMIT;
                case (action_reg)
                    ACT_LOOKUP:
                    begin
                        res_next = found_reg ? ST_FOUND : ST_NOTFOUND;
                    end
                    ACT_INSERT:
                    begin
                        if (found_reg)
                        begin
                            res_next = ST_PRESENT;
                        end
                        else if (count_reg == CNT_W'(TABLE_DEPTH))
                        begin
                            res_next = ST_FULL;
                        end
                        else
                        begin
                            // open a slot at pos by moving keys up from the top
                            idx_next   = count_reg;
                            state_next = S_IRD;
                        end
                    end
                    ACT_DELETE:
                    begin
                        if (found_reg)
                        begin
                            idx_next   = pos_reg;
                            state_next = S_DRD;
                        end
                        else
                        begin
                            res_next = ST_ABSENT;
                        end
                    end
                    default:
                    begin
                        res_next = ST_EMPTY;
                    end
                endcase
            end

            S_IRD:
            begin
                if (idx_reg == pos_reg)
                begin
                    wr_en      = 1'b1;
                    wr_data    = key_reg;
                    count_next = CNT_W'(count_reg + 1'b1);
                    res_next   = ST_INSERTED;
                    state_next = S_EMIT;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_dec[ADDR_W-1:0];
                    state_next = S_IWR;
                end
            end

            S_IWR:
            begin
                wr_en      = 1'b1;
                idx_next   = idx_dec;
                state_next = S_IRD;
            end

            S_DRD:
            begin
                if (idx_inc >= count_reg)
                begin
                    // gap closed up to the top
                    count_next = CNT_W'(count_reg - 1'b1);
                    res_next   = ST_REMOVED;
                    state_next = S_EMIT;
                end
                else
                begin
                    rd_en      = 1'b1;
                    rd_addr    = idx_inc[ADDR_W-1:0];
                    state_next = S_DWR;
                end
            end

            S_DWR:
            begin
                wr_en      = 1'b1;
                idx_next   = idx_inc;
                state_next = S_DRD;
            end

            S_DUMP_RD:
            begin
                rd_en      = 1'b1;
                state_next = S_DUMP_OUT;
            end

            S_DUMP_OUT:
            begin
                // ram read data holds while the output register is busy
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = ST_LISTED;
                    key_out_next   = rd_data;
                    last_next      = (idx_inc == count_reg);
                    idx_next       = idx_inc;
                    state_next     = (idx_inc == count_reg) ? S_IDLE : S_DUMP_RD;
                end
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = res_reg;
                    key_out_next   = key_reg;
                    last_next      = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // request payload and output word, no reset needed
    always_ff @(posedge clk)
    begin
        pos_reg     <= pos_next;
        found_reg   <= found_next;
        action_reg  <= action_next;
        key_reg     <= key_next;
        res_reg     <= res_next;
        status_reg  <= status_next;
        key_out_reg <= key_out_next;
        last_reg    <= last_next;
    end

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign key_out   = key_out_reg;
    assign last      = last_reg;

    // entry count never passes the table size
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

    // the ram never sees a read and a write in the same cycle
    a_ram_port: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && rd_en))
    else $error("ram read and write overlap");

    // completing an insert grows the table by exactly one
    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IRD && idx_reg == pos_reg) |=>
        count_reg == CNT_W'($past(count_reg) + 1'b1))
    else $error("insert did not grow the count");

    // a dump word is only produced from a non-empty table
    a_dump_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DUMP_OUT) |-> (count_reg != '0 && idx_reg < count_reg))
    else $error("dump read beyond stored keys");

    // an output word is not overwritten before it is taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(key_out_reg)))
    else $error("output word overwritten");

endmodule

@@ src/skst_ram.sv @@
// generic simple dual port ram with registered read
module skst_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ verif/sorted_set_monitor.sv @@
// checker for the sorted key set table: predicts result words and compares them
`timescale 1ns / 1ps

module sorted_set_monitor
    import skst_pkg::*;
#(
    parameter int TABLE_DEPTH = 64
) (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    input  logic    in_ready,
    input  action_t action,
    input  key_t    key,
    input  logic    out_valid,
    input  logic    out_ready,
    input  status_t status,
    input  key_t    key_out,
    input  logic    last,
    input  logic    end_of_run,
    output int      fail_count,
    output int      outstanding,
    output int      requests_seen,
    output int      words_seen
);

    typedef struct packed {
        status_t status;
        key_t    key;
        logic    last;
    } result_word_t;

    // predicted table contents, ascending
    key_t         held_keys [TABLE_DEPTH];
    int           held = 0;
    result_word_t awaited_words [$];
    bit           leftovers_reported = 1'b0;

    initial
    begin
        fail_count    = 0;
        outstanding   = 0;
        requests_seen = 0;
        words_seen    = 0;
    end

    function automatic result_word_t make_word(status_t s, key_t k, logic l);
        result_word_t w;
        w.status = s;
        w.key    = k;
        w.last   = l;
        return w;
    endfunction

    task automatic predict_request(input action_t act, input key_t k);
        int pos;
        bit hit;
        pos = 0;
        while (pos < held && held_keys[pos] < k)
            pos++;
        hit = (pos < held) && (held_keys[pos] == k);
        case (act)
            ACT_LOOKUP:
                awaited_words.push_back(make_word(hit ? ST_FOUND : ST_NOTFOUND, k, 1'b1));
            ACT_INSERT:
            begin
                if (hit)
                    awaited_words.push_back(make_word(ST_PRESENT, k, 1'b1));
                else if (held >= TABLE_DEPTH)
                    awaited_words.push_back(make_word(ST_FULL, k, 1'b1));
                else
                begin
                    for (int i = held; i > pos; i--)
                        held_keys[i] = held_keys[i-1];
                    held_keys[pos] = k;
                    held++;
                    awaited_words.push_back(make_word(ST_INSERTED, k, 1'b1));
                end
            end
            ACT_DELETE:
            begin
                if (hit)
                begin
                    for (int i = pos; i + 1 < held; i++)
                        held_keys[i] = held_keys[i+1];
                    held--;
                    awaited_words.push_back(make_word(ST_REMOVED, k, 1'b1));
                end
                else
                    awaited_words.push_back(make_word(ST_ABSENT, k, 1'b1));
            end
            ACT_DUMP:
            begin
                if (held == 0)
                    awaited_words.push_back(make_word(ST_EMPTY, '0, 1'b1));
                else
                    for (int i = 0; i < held; i++)
                        awaited_words.push_back(make_word(ST_LISTED, held_keys[i],
                                                          i == held - 1));
            end
        endcase
    endtask

    always @(posedge clk)
    begin
        result_word_t want;
        if (!rst_n)
        begin
            held = 0;
            awaited_words.delete();
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_request(action, key);
                requests_seen++;
            end
            if (out_valid && out_ready)
            begin
                words_seen++;
                if (awaited_words.size() == 0)
                begin
                    $display("%0t: unexpected word: expected none, actual status %0d key %h last %b",
                             $time, status, key_out, last);
                    fail_count++;
                end
                else
                begin
                    want = awaited_words.pop_front();
                    if (status !== want.status)
                    begin
                        $display("%0t: status mismatch: expected %0d, actual %0d",
                                 $time, want.status, status);
                        fail_count++;
                    end
                    if (key_out !== want.key)
                    begin
                        $display("%0t: key_out mismatch: expected %h, actual %h",
                                 $time, want.key, key_out);
                        fail_count++;
                    end
                    if (last !== want.last)
                    begin
                        $display("%0t: last mismatch: expected %b, actual %b",
                                 $time, want.last, last);
                        fail_count++;
                    end
                end
            end
            if (end_of_run && !leftovers_reported)
            begin
                leftovers_reported = 1'b1;
                if (awaited_words.size() != 0)
                begin
                    $display("%0t: missing words: expected %0d more, actual none",
                             $time, awaited_words.size());
                    fail_count += awaited_words.size();
                end
            end
        end
        outstanding = awaited_words.size();
    end

endmodule

@@ verif/testbench.sv @@
// top of the sorted key set table testbench: stimulus, idling phases and verdict
`timescale 1ns / 1ps

module testbench;
    import skst_pkg::*;

    localparam int   DEPTH          = 64;
    localparam int   WATCHDOG_LIMIT = 5000;
    localparam key_t KEY_MAX        = 31'h7fff_ffff;

    logic    clk        = 1'b0;
    logic    rst_n      = 1'b0;
    logic    in_valid   = 1'b0;
    logic    in_ready;
    action_t action     = ACT_LOOKUP;
    key_t    key        = '0;
    logic    out_valid;
    logic    out_ready  = 1'b0;
    status_t status;
    key_t    key_out;
    logic    last;
    logic    end_of_run = 1'b0;

    int fail_count;
    int outstanding;
    int requests_seen;
    int words_seen;

    // idling phases: none, sender idle, receiver stalling, both
    int sender_idle    [4] = '{0, 84, 0, 38};
    int receiver_stall [4] = '{0, 0, 84, 38};
    int in_idle_pct        = 0;
    int out_stall_pct      = 0;
    int quiet_cycles       = 0;

    // keys believed stored, unordered; steers key choice toward hits and bounds the fill loop
    key_t live [$];

    always #1 clk = ~clk;

    sorted_key_set_table #(
        .TABLE_DEPTH (DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .action    (action),
        .key       (key),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .key_out   (key_out),
        .last      (last)
    );

    sorted_set_monitor #(
        .TABLE_DEPTH (DEPTH)
    ) monitor (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .action        (action),
        .key           (key),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .key_out       (key_out),
        .last          (last),
        .end_of_run    (end_of_run),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .requests_seen (requests_seen),
        .words_seen    (words_seen)
    );

    // receiver back-pressure, redrawn every cycle at the falling edge
    always @(negedge clk)
        out_ready <= ($urandom_range(99) >= out_stall_pct);

    // watchdog: a long stretch with no word moving on either side means a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
                $display("testbench failed");
                $finish;
            end
        end
    end

    function automatic int live_index(key_t k);
        foreach (live[i])
            if (live[i] == k)
                return i;
        return -1;
    endfunction

    // mix of stored keys, a small crowded range, the extremes and full-width keys
    function automatic key_t pick_key();
        int r;
        r = $urandom_range(99);
        if (r < 40 && live.size() > 0)
            return live[$urandom_range(live.size() - 1)];
        else if (r < 65)
            return key_t'($urandom_range(15));
        else if (r < 72)
            return '0;
        else if (r < 79)
            return KEY_MAX;
        else
            return key_t'($urandom());
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_word(input action_t a, input key_t k);
        int idx;
        idx = live_index(k);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        action   <= a;
        key      <= k;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
        if (a == ACT_INSERT && idx < 0 && live.size() < DEPTH)
            live.push_back(k);
        else if (a == ACT_DELETE && idx >= 0)
            live.delete(idx);
    endtask

    task automatic random_request();
        int r;
        r = $urandom_range(99);
        if (r < 30)
            send_word(ACT_INSERT, pick_key());
        else if (r < 55)
            send_word(ACT_DELETE, pick_key());
        else if (r < 85)
            send_word(ACT_LOOKUP, pick_key());
        else
            send_word(ACT_DUMP, key_t'($urandom()));
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty table behavior
        send_word(ACT_DUMP, '0);
        send_word(ACT_LOOKUP, '0);
        send_word(ACT_DELETE, KEY_MAX);
        // insert in the middle, at the front, appended past the largest
        send_word(ACT_INSERT, 31'd1000);
        send_word(ACT_INSERT, '0);
        send_word(ACT_INSERT, KEY_MAX);
        send_word(ACT_INSERT, 31'd500);
        send_word(ACT_INSERT, 31'd1000);
        send_word(ACT_LOOKUP, '0);
        send_word(ACT_LOOKUP, KEY_MAX);
        send_word(ACT_LOOKUP, 31'd501);
        send_word(ACT_DUMP, 31'h2aaa_aaaa);
        // delete from middle, a missing key, the front and the end
        send_word(ACT_DELETE, 31'd500);
        send_word(ACT_DELETE, 31'd500);
        send_word(ACT_DELETE, '0);
        send_word(ACT_DELETE, KEY_MAX);
        send_word(ACT_LOOKUP, KEY_MAX);
        // alternating bit patterns on the key
        send_word(ACT_INSERT, 31'h2aaa_aaaa);
        send_word(ACT_INSERT, 31'h5555_5555);
        send_word(ACT_DUMP, '0);
        send_word(ACT_DELETE, 31'd1000);
        send_word(ACT_DELETE, 31'h2aaa_aaaa);
        send_word(ACT_DELETE, 31'h5555_5555);
        // dump ignores its key, table is empty again
        send_word(ACT_DUMP, KEY_MAX);

        // fill to capacity with keys that stay below the largest key
        while (live.size() < DEPTH)
            send_word(ACT_INSERT, key_t'($urandom_range(32'h3fff_ffff, 1)));
        // full table: a key past the largest is refused, a present key still reports
        send_word(ACT_INSERT, KEY_MAX);
        send_word(ACT_INSERT, live[$urandom_range(DEPTH - 1)]);
        send_word(ACT_INSERT, key_t'($urandom_range(32'h3fff_ffff, 1)));
        send_word(ACT_LOOKUP, live[0]);
        send_word(ACT_DUMP, key_t'($urandom()));
        repeat (30)
            send_word(ACT_DELETE, live[$urandom_range(live.size() - 1)]);

        // random requests through every idling phase
        for (int phase = 0; phase < 4; phase++)
        begin
            in_idle_pct   = sender_idle[phase];
            out_stall_pct = receiver_stall[phase];
            repeat (55)
                random_request();
        end
        in_valid <= 1'b0;

        // drain, then give a stray word time to show up
        while (outstanding != 0)
            @(negedge clk);
        repeat (300) @(negedge clk);
        end_of_run <= 1'b1;
        @(negedge clk);
        @(negedge clk);

        $display("covered %0d requests and %0d result words: empty, full and crowded tables",
                 requests_seen, words_seen);
        $display("idling phases: none, sender idle, receiver stalling, both; %0d failures",
                 fail_count);
        if (fail_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule
